@@ rtl/core/cov_pkg.sv @@
// shared widths and divider request/response types for the multiples counter
package cov_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0]   data_t;
  typedef logic [2*DATA_WIDTH-1:0] wide_t;

  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
    data_t remainder;
  } div_rsp_t;

endpackage

@@ rtl/core/cov_div.sv @@
// shared restoring divider, one quotient bit per cycle
module cov_div (
  input  logic              clk,
  input  logic              rst,
  input  cov_pkg::div_req_t req,
  output cov_pkg::div_rsp_t rsp
);
  import cov_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  data_t            rem;
  data_t            quo;
  data_t            dvs;
  logic [DATA_WIDTH:0] partial;
  logic [DATA_WIDTH:0] trial;
  logic                borrow;

  // shift in the next dividend bit and try to subtract
  assign partial = {rem, quo[DATA_WIDTH-1]};
  assign trial   = partial - {1'b0, dvs};
  assign borrow  = trial[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_WIDTH);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= borrow ? partial[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], ~borrow};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(req.start && busy))
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

@@ rtl/core/count_multiples_of_either_core.sv @@
// top level: counts integers in 1..n divisible by a or b (inclusion-exclusion)
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid, in_stall                        | limit, divisor_first, divisor_second
//  out     | out_valid, out_stall                      | union_count, zero_divisor
//
// each word runs k + 4 divisions between its acceptance and the next
// acceptance, k being the number of euclidean steps; every division is a load cycle,
// DATA_WIDTH shift steps and a done cycle on the one shared bit-serial divider
// an lcm above the limit skips the overlap division, (k + 3) passes instead of (k + 4)
// a zero divisor skips the arithmetic and goes straight to the output step
// in_stall is high from acceptance until the cycle after the result enters the output register
// a result waiting on out_stall holds there while the next word is taken in
// rst is synchronous, active high, and clears the sequencer and out_valid
module count_multiples_of_either_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] limit,
  input  logic [31:0] divisor_first,
  input  logic [31:0] divisor_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] union_count,
  output logic        zero_divisor
);
  import cov_pkg::*;

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_GCD    = 9'b000000010,
    S_LCMDIV = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_CNT_A  = 9'b000010000,
    S_CNT_B  = 9'b000100000,
    S_CNT_L  = 9'b001000000,
    S_SUM    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t   state;
  logic     launch;     // one-cycle start for the divider
  data_t    n_reg;      // limit
  data_t    a_reg;      // first divisor
  data_t    b_reg;      // second divisor
  data_t    gx;         // euclid dividend
  data_t    gy;         // euclid divisor, ends as the gcd
  data_t    qg;         // a / gcd
  wide_t    lcm;        // double-width lcm, never overflows
  data_t    acc;        // running inclusion-exclusion sum
  logic     zflag;
  data_t    n_in;
  data_t    a_in;
  data_t    b_in;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // only the low DATA_WIDTH bits of each field take part
  assign n_in = data_t'(limit);
  assign a_in = data_t'(divisor_first);
  assign b_in = data_t'(divisor_second);

  assign in_stall = (state != S_IDLE);

  // operand select for the shared divider
  always_comb begin
    div_req.start = launch;
    case (state)
      S_GCD: begin
        div_req.dividend = gx;
        div_req.divisor  = gy;
      end
      S_LCMDIV: begin
        div_req.dividend = a_reg;
        div_req.divisor  = gy;
      end
      S_CNT_A: begin
        div_req.dividend = n_reg;
        div_req.divisor  = a_reg;
      end
      S_CNT_B: begin
        div_req.dividend = n_reg;
        div_req.divisor  = b_reg;
      end
      S_CNT_L: begin
        div_req.dividend = n_reg;
        div_req.divisor  = lcm[DATA_WIDTH-1:0];
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  cov_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n_reg <= n_in;
            a_reg <= a_in;
            b_reg <= b_in;
            if (a_in == '0 || b_in == '0) begin
              // zero divisor: count forced to zero
              acc   <= '0;
              zflag <= 1'b1;
              state <= S_SUM;
            end else begin
              gx     <= a_in;
              gy     <= b_in;
              zflag  <= 1'b0;
              launch <= 1'b1;
              state  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (div_rsp.done) begin
            launch <= 1'b1;
            if (div_rsp.remainder == '0) begin
              state <= S_LCMDIV;   // gy holds the gcd
            end else begin
              gx <= gy;
              gy <= div_rsp.remainder;
            end
          end
        end
        S_LCMDIV: begin
          if (div_rsp.done) begin
            qg    <= div_rsp.quotient;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          lcm    <= wide_t'(qg) * wide_t'(b_reg);
          launch <= 1'b1;
          state  <= S_CNT_A;
        end
        S_CNT_A: begin
          if (div_rsp.done) begin
            acc    <= div_rsp.quotient;
            launch <= 1'b1;
            state  <= S_CNT_B;
          end
        end
        S_CNT_B: begin
          if (div_rsp.done) begin
            acc <= acc + div_rsp.quotient;
            // lcm above the limit: no overlap to take back
            if (lcm > wide_t'(n_reg)) begin
              state <= S_SUM;
            end else begin
              launch <= 1'b1;
              state  <= S_CNT_L;
            end
          end
        end
        S_CNT_L: begin
          if (div_rsp.done) begin
            acc   <= acc - div_rsp.quotient;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // wait here until the output register is free
          if (!out_valid || !out_stall) begin
            union_count  <= 32'(acc);
            zero_divisor <= zflag;
            out_valid    <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (union_count == '0))
    else $error("zero divisor with nonzero count");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted word did not start the sequencer");

  a_launch_state: assert property (@(posedge clk) disable iff (rst)
    launch |-> (state == S_GCD || state == S_LCMDIV || state == S_CNT_A ||
                state == S_CNT_B || state == S_CNT_L))
    else $error("divider launched outside a divide step");

  a_sum_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && (!out_valid || !out_stall)) |=> out_valid)
    else $error("result not loaded into output register");

endmodule

@@ tb/tb.sv @@
// testbench for count_multiples_of_either_core: directed and random words, union counts checked
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cov_pkg::*;

  // slowest word is about 50 divider passes, so this is several times the worst run
  localparam int CYCLE_LIMIT  = 6_000_000;
  // longest single word latency plus margin, used for the quiet stretch at the end
  localparam int DRAIN_CYCLES = 2000;
  localparam int RANDOM_WORDS = 1125;
  // long receiver hold-off, far longer than a small-divisor word takes
  localparam int HOLD_OFF     = 4000;

  // one expected result word
  typedef struct packed {
    logic [31:0] count;
    logic        zero_div;
  } union_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] limit;
  logic [31:0] divisor_first;
  logic [31:0] divisor_second;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] union_count;
  logic        zero_divisor;

  union_word_t pending_counts[$];
  int          errors          = 0;
  int          cycle_count     = 0;
  bit          idling          = 1'b1;
  int          hold_off_cycles = 0;

  count_multiples_of_either_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .limit         (limit),
    .divisor_first (divisor_first),
    .divisor_second(divisor_second),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .union_count   (union_count),
    .zero_divisor  (zero_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // inclusion-exclusion count of multiples of a or b in 1..n, lcm kept at double width
  function automatic union_word_t predict_union_count(logic [31:0] n_in, logic [31:0] a_in,
                                                      logic [31:0] b_in);
    data_t       n = n_in;
    data_t       a = a_in;
    data_t       b = b_in;
    wide_t       x;
    wide_t       y;
    wide_t       r;
    wide_t       lcm;
    wide_t       overlap;
    wide_t       total;
    union_word_t w;
    w.count    = '0;
    w.zero_div = 1'b0;
    if (a == '0 || b == '0) begin
      // any zero divisor: flag set, count forced to zero
      w.zero_div = 1'b1;
      return w;
    end
    x = wide_t'(a);
    y = wide_t'(b);
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    lcm     = (wide_t'(a) / x) * wide_t'(b);
    // lcm above the limit means no common multiple in range
    overlap = (lcm > wide_t'(n)) ? '0 : wide_t'(n) / lcm;
    total   = wide_t'(n) / wide_t'(a) + wide_t'(n) / wide_t'(b) - overlap;
    w.count = total[31:0];
    return w;
  endfunction

  // offer one word, after a random gap when idling, and log its expected result once it is taken
  task automatic send_word(input logic [31:0] n, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = idling ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    limit          <= n;
    divisor_first  <= a;
    divisor_second <= b;
    do @(posedge clk); while (in_stall);
    pending_counts.push_back(predict_union_count(n, a, b));
  endtask

  // divisor mix: zero now and then, small values, powers of two, near-max, full range
  function automatic logic [31:0] draw_divisor();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 32'd0;
    if (pick <= 6) return $urandom_range(1, 64);
    if (pick <= 9) return 32'd1 << $urandom_range(0, 31);
    if (pick <= 11) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic logic [31:0] draw_limit();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 100);
    if (pick == 1) return 32'hFFFF_FFFF - $urandom_range(0, 255);
    return $urandom;
  endfunction

  task automatic test_zero_divisor();
    send_word(32'd100, 32'd0, 32'd7);
    send_word(32'd100, 32'd7, 32'd0);
    send_word(32'd0, 32'd0, 32'd0);
    send_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_word(32'd0, 32'd5, 32'd0);
  endtask

  task automatic test_boundaries();
    // empty range
    send_word(32'd0, 32'd3, 32'd5);
    send_word(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // full overlap: every multiple in range counts once
    send_word(32'hFFFF_FFFF, 32'd1, 32'd1);
    send_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // lcm close to 2^64, far above the limit
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    // ordinary overlap and equal divisors
    send_word(32'd1000, 32'd6, 32'd10);
    send_word(32'd1000, 32'd7, 32'd7);
    send_word(32'd1000, 32'd999, 32'd1000);
    // consecutive fibonacci numbers: longest euclidean chain at 32 bits
    send_word(32'hFFFF_FFFF, 32'd2971215073, 32'd1836311903);
    send_word(32'hFFFF_FFFF, 32'd1836311903, 32'd2971215073);
    // limit just below and equal to the divisors
    send_word(32'd29, 32'd30, 32'd31);
    send_word(32'd30, 32'd30, 32'd30);
    send_word(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000);
    send_word(32'h8000_0000, 32'd3, 32'd2);
  endtask

  task automatic test_random_words(input int count);
    logic [31:0] n;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] common;
    for (int i = 0; i < count; i++) begin
      // switch between idling and back-to-back stretches
      if (i % 100 == 0) idling = ($urandom_range(0, 3) != 0);
      n = draw_limit();
      if ($urandom_range(0, 3) == 0) begin
        // shared factor so the overlap term is non-trivial
        common = $urandom_range(1, 5000);
        a      = common * $urandom_range(1, 300);
        b      = common * $urandom_range(1, 300);
      end else begin
        a = draw_divisor();
        b = draw_divisor();
      end
      send_word(n, a, b);
    end
    idling = 1'b1;
  endtask

  // receiver holds off for a long stretch while words keep coming, so the core fills up
  task automatic test_output_backpressure();
    idling          = 1'b0;
    hold_off_cycles = HOLD_OFF;
    for (int i = 0; i < 6; i++) begin
      send_word(draw_limit(), $urandom_range(1, 200), $urandom_range(1, 200));
    end
    idling = 1'b1;
  endtask

  // receiver side: random stall per word, plus the long hold-off when requested
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        wait_cycles = idling ? $urandom_range(0, 4) : 0;
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          // only count cycles where a word is actually waiting
          while (wait_cycles > 0) begin
            @(posedge clk);
            if (out_valid) wait_cycles--;
          end
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every word taken from the core against the oldest expectation
  always @(posedge clk) begin
    union_word_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected word: count %0d zero_divisor %0b", $time, union_count,
                 zero_divisor);
        errors++;
      end else begin
        exp_word = pending_counts.pop_front();
        if (union_count !== exp_word.count) begin
          $display("%0t: union_count mismatch: expected %0d actual %0d", $time,
                   exp_word.count, union_count);
          errors++;
        end
        if (zero_divisor !== exp_word.zero_div) begin
          $display("%0t: zero_divisor mismatch: expected %0b actual %0b", $time,
                   exp_word.zero_div, zero_divisor);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** count_multiples_of_either_core: FAILED **");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    limit          <= '0;
    divisor_first  <= '0;
    divisor_second <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_divisor();
    test_boundaries();
    test_output_backpressure();
    test_random_words(RANDOM_WORDS);
    in_valid <= 1'b0;

    // drain, then stay quiet long enough to catch any stray word
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** count_multiples_of_either_core: PASSED **");
    end else begin
      $display("** count_multiples_of_either_core: FAILED **");
    end
    $finish;
  end

endmodule
